/* src/bpa_pkg.sv */
// shared constants, codes and controller/datapath types for the buddy page allocator
package bpa_pkg;

   // pool size defaults
   localparam int PAGES_DEF      = 1024;
   localparam int NUM_ORDERS_DEF = 11;

   // fixed field widths
   localparam int ACTION_W = 2;
   localparam int ORDER_W  = 4;
   localparam int PAGE_W   = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // page count register value out of reset
   localparam logic [COUNT_W-1:0] POOL_PAGES_RESET = 11'd1024;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOBLK = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

   // datapath operations
   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_CLR,
      OP_INIT_SETUP,
      OP_INIT_DEC,
      OP_INIT_PLACE,
      OP_PUSH_B,
      OP_ALLOC_SETUP,
      OP_ORD_INC,
      OP_TAKE,
      OP_REM_RD,
      OP_REM_WR,
      OP_SPLIT,
      OP_ALLOC_DONE,
      OP_FREE_RD,
      OP_FREE_OK,
      OP_MERGE_RD,
      OP_MERGE_TAKE,
      OP_FREE_FIN
   } dp_op_type;

   // kind of result beat
   typedef enum logic [1:0] {
      RES_INIT,
      RES_BLOCK,
      RES_NOBLK,
      RES_BAD
   } res_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         res_load;
      res_kind_type res_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic                clr_last;
      logic [ACTION_W-1:0] action;
      logic                req_ok;
      logic                n_zero;
      logic                pos_done;
      logic                fits;
      logic                ord_at_max;
      logic                head_valid;
      logic                split_more;
      logic                free_ok;
      logic                merge_try;
      logic                buddy_match;
      logic                out_free;
   } dp_stat_type;

endpackage

/* src/bpa_if.sv */
// valid/ready channel interfaces for request, response and page count write
interface bpa_req_if;
   import bpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ORDER_W-1:0]  request_order;
   logic [PAGE_W-1:0]   page_index;
   modport source (output valid, action, request_order, page_index, input ready);
   modport sink (input valid, action, request_order, page_index, output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   block_index;
   logic [ORDER_W-1:0]  block_order;
   logic [COUNT_W-1:0]  free_pages;
   modport source (output valid, status, block_index, block_order, free_pages, input ready);
   modport sink (input valid, status, block_index, block_order, free_pages, output ready);
endinterface

interface bpa_csr_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* src/bpa_datapath.sv */
// allocator datapath: block metadata and free list memories, list heads, counters
module bpa_datapath #(
   parameter int PAGES      = bpa_pkg::PAGES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bpa_pkg::dp_cmd_type            cmd,
   output bpa_pkg::dp_stat_type           stat,
   input  logic [bpa_pkg::ACTION_W-1:0]   req_action,
   input  logic [bpa_pkg::ORDER_W-1:0]    req_request_order,
   input  logic [bpa_pkg::PAGE_W-1:0]     req_page_index,
   input  logic                           csr_write,
   input  logic [bpa_pkg::COUNT_W-1:0]    csr_data,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]     rsp_block_index,
   output logic [bpa_pkg::ORDER_W-1:0]    rsp_block_order,
   output logic [bpa_pkg::COUNT_W-1:0]    rsp_free_pages
);
   import bpa_pkg::*;

   localparam int AW = $clog2(PAGES);
   localparam int CW = $clog2(PAGES + 1);
   localparam int OW = $clog2(NUM_ORDERS + 1);
   localparam int HW = $clog2(NUM_ORDERS);
   localparam int MW = OW + 2;
   localparam logic [CW-1:0] NIL = CW'(PAGES);

   // metadata word: alloc flag, free flag, order
   localparam int M_ALLOC = OW + 1;
   localparam int M_FREE  = OW;

   logic [MW-1:0] meta_mem [PAGES];
   logic [CW-1:0] next_mem [PAGES];
   logic [CW-1:0] prev_mem [PAGES];

   logic [COUNT_W-1:0]  csr_pages_ff, csr_pages_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [ORDER_W-1:0]  req_ff, req_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [CW-1:0]       pool_ff, pool_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [OW-1:0]       ord_ff, ord_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       tgt_ff, tgt_in;
   logic [CW-1:0]       h_ff, h_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CW-1:0]       head_ff [NUM_ORDERS];
   logic [CW-1:0]       head_in [NUM_ORDERS];
   logic [MW-1:0]       meta_rd_ff;
   logic [CW-1:0]       next_rd_ff, prev_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [ORDER_W-1:0]  rsp_order_ff, rsp_order_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   // memory port controls
   logic          meta_we, meta_re;
   logic [AW-1:0] meta_wa, meta_ra;
   logic [MW-1:0] meta_wd;
   logic          next_we, prev_we, link_re;
   logic [AW-1:0] next_wa, prev_wa;
   logic [CW-1:0] next_wd, prev_wd;

   // derived values
   logic [CW-1:0] sz, sz_o, head_cur, head_o, b_x;
   logic [OW-1:0] ord_o, top_ord, rd_ord_clamped;
   logic [AW-1:0] b_split, page_addr;
   logic [CW:0]   pos_end;
   logic          head_valid;

   assign page_addr = AW'(page_ff);
   assign sz        = CW'(1) << ord_ff;
   assign ord_o     = ord_ff - 1'b1;
   assign sz_o      = CW'(1) << ord_o;
   assign head_cur  = (32'(ord_ff) < NUM_ORDERS) ? head_ff[ord_ff[HW-1:0]] : NIL;
   assign head_o    = head_ff[ord_o[HW-1:0]];
   assign head_valid = head_cur < NIL;
   assign b_split   = AW'(CW'(idx_ff) + sz_o);
   assign b_x       = CW'(idx_ff) ^ sz;
   assign pos_end   = {1'b0, pos_ff} + {1'b0, sz};
   assign rd_ord_clamped = (32'(meta_rd_ff[OW-1:0]) >= NUM_ORDERS) ?
                           OW'(NUM_ORDERS - 1) : meta_rd_ff[OW-1:0];

   // largest order whose block fits in the pool
   always_comb begin
      top_ord = '0;
      for (int k = 1; k < NUM_ORDERS; k++) begin
         if (({1'b0, CW'(1)} << k) <= {1'b0, n_ff}) begin
            top_ord = OW'(k);
         end
      end
   end

   // status to the controller
   always_comb begin
      stat.clr_last    = 32'(clr_ff) == PAGES - 1;
      stat.action      = action_ff;
      stat.req_ok      = 32'(req_ff) < NUM_ORDERS;
      stat.n_zero      = n_ff == '0;
      stat.pos_done    = pos_ff >= n_ff;
      stat.fits        = pos_end <= {1'b0, n_ff};
      stat.ord_at_max  = 32'(ord_ff) >= NUM_ORDERS;
      stat.head_valid  = head_valid;
      stat.split_more  = 32'(ord_ff) > 32'(req_ff);
      stat.free_ok     = (32'(page_ff) < 32'(pool_ff)) && (32'(page_ff) < PAGES) &&
                         meta_rd_ff[M_ALLOC];
      stat.merge_try   = (32'(ord_ff) + 1 < NUM_ORDERS) && (b_x < pool_ff);
      stat.buddy_match = meta_rd_ff[M_FREE] && (meta_rd_ff[OW-1:0] == ord_ff);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // next state of registers and memory controls per operation
   always_comb begin
      csr_pages_in = csr_write ? csr_data : csr_pages_ff;
      action_in = action_ff;
      req_in    = req_ff;
      page_in   = page_ff;
      n_in      = n_ff;
      pool_in   = pool_ff;
      total_in  = total_ff;
      pos_in    = pos_ff;
      ord_in    = ord_ff;
      idx_in    = idx_ff;
      tgt_in    = tgt_ff;
      h_in      = h_ff;
      clr_in    = clr_ff;
      for (int k = 0; k < NUM_ORDERS; k++) begin
         head_in[k] = head_ff[k];
      end
      meta_we = 1'b0;
      meta_wa = '0;
      meta_wd = '0;
      meta_re = 1'b0;
      meta_ra = '0;
      next_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = '0;
      link_re = 1'b0;

      unique case (cmd.op)
         OP_IDLE: begin
         end
         OP_LOAD: begin
            action_in = req_action;
            req_in    = req_request_order;
            page_in   = req_page_index;
            if (32'(csr_pages_ff) > PAGES) begin
               n_in = NIL;
            end else begin
               n_in = CW'(csr_pages_ff);
            end
         end
         OP_CLR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            meta_wd = '0;
            clr_in  = (32'(clr_ff) == PAGES - 1) ? '0 : clr_ff + 1'b1;
         end
         OP_INIT_SETUP: begin
            for (int k = 0; k < NUM_ORDERS; k++) begin
               head_in[k] = NIL;
            end
            total_in = '0;
            pool_in  = n_ff;
            ord_in   = top_ord;
            pos_in   = '0;
         end
         OP_INIT_DEC: begin
            ord_in = ord_o;
         end
         OP_INIT_PLACE: begin
            tgt_in   = pos_ff[AW-1:0];
            meta_we  = 1'b1;
            meta_wa  = pos_ff[AW-1:0];
            meta_wd  = {1'b0, 1'b1, ord_ff};
            next_we  = 1'b1;
            next_wa  = pos_ff[AW-1:0];
            next_wd  = head_cur;
            prev_we  = 1'b1;
            prev_wa  = pos_ff[AW-1:0];
            prev_wd  = NIL;
            h_in     = head_cur;
            total_in = total_ff + sz;
            pos_in   = pos_end[CW-1:0];
         end
         OP_PUSH_B: begin
            if (h_ff < NIL) begin
               prev_we = 1'b1;
               prev_wa = h_ff[AW-1:0];
               prev_wd = CW'(tgt_ff);
            end
            head_in[ord_ff[HW-1:0]] = CW'(tgt_ff);
         end
         OP_ALLOC_SETUP: begin
            ord_in = OW'(req_ff);
         end
         OP_ORD_INC: begin
            ord_in = ord_ff + 1'b1;
         end
         OP_TAKE: begin
            idx_in = head_cur[AW-1:0];
            tgt_in = head_cur[AW-1:0];
         end
         OP_REM_RD: begin
            link_re = 1'b1;
         end
         OP_REM_WR: begin
            if (prev_rd_ff < NIL) begin
               next_we = 1'b1;
               next_wa = prev_rd_ff[AW-1:0];
               next_wd = next_rd_ff;
            end else begin
               head_in[ord_ff[HW-1:0]] = next_rd_ff;
            end
            if (next_rd_ff < NIL) begin
               prev_we = 1'b1;
               prev_wa = next_rd_ff[AW-1:0];
               prev_wd = prev_rd_ff;
            end
         end
         OP_SPLIT: begin
            ord_in  = ord_o;
            tgt_in  = b_split;
            meta_we = 1'b1;
            meta_wa = b_split;
            meta_wd = {1'b0, 1'b1, ord_o};
            next_we = 1'b1;
            next_wa = b_split;
            next_wd = head_o;
            prev_we = 1'b1;
            prev_wa = b_split;
            prev_wd = NIL;
            h_in    = head_o;
         end
         OP_ALLOC_DONE: begin
            meta_we  = 1'b1;
            meta_wa  = idx_ff;
            meta_wd  = {1'b1, 1'b0, ord_ff};
            total_in = total_ff - sz;
         end
         OP_FREE_RD: begin
            meta_re = 1'b1;
            meta_ra = page_addr;
         end
         OP_FREE_OK: begin
            idx_in   = page_addr;
            ord_in   = rd_ord_clamped;
            total_in = total_ff + (CW'(1) << rd_ord_clamped);
            meta_we  = 1'b1;
            meta_wa  = page_addr;
            meta_wd  = {1'b0, 1'b0, meta_rd_ff[OW-1:0]};
         end
         OP_MERGE_RD: begin
            meta_re = 1'b1;
            meta_ra = b_x[AW-1:0];
            tgt_in  = b_x[AW-1:0];
         end
         OP_MERGE_TAKE: begin
            meta_we = 1'b1;
            meta_wa = tgt_ff;
            meta_wd = {1'b0, 1'b0, meta_rd_ff[OW-1:0]};
            idx_in  = idx_ff & tgt_ff;
         end
         OP_FREE_FIN: begin
            tgt_in  = idx_ff;
            meta_we = 1'b1;
            meta_wa = idx_ff;
            meta_wd = {1'b0, 1'b1, ord_ff};
            next_we = 1'b1;
            next_wa = idx_ff;
            next_wd = head_cur;
            prev_we = 1'b1;
            prev_wa = idx_ff;
            prev_wd = NIL;
            h_in    = head_cur;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_free_in   = rsp_free_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = '0;
         rsp_order_in = '0;
         rsp_free_in  = COUNT_W'(total_ff);
         unique case (cmd.res_kind)
            RES_INIT: rsp_status_in = ST_OK;
            RES_BLOCK: begin
               rsp_status_in = ST_OK;
               rsp_index_in  = PAGE_W'(idx_ff);
               rsp_order_in  = ORDER_W'(ord_ff);
            end
            RES_NOBLK: rsp_status_in = ST_NOBLK;
            RES_BAD: rsp_status_in = ST_BAD;
            default: rsp_status_in = ST_BAD;
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (meta_re) begin
         meta_rd_ff <= meta_mem[meta_ra];
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (link_re) begin
         next_rd_ff <= next_mem[tgt_ff];
         prev_rd_ff <= prev_mem[tgt_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_pages_ff <= POOL_PAGES_RESET;
         pool_ff      <= '0;
         total_ff     <= '0;
         clr_ff       <= '0;
         ord_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_ORDERS; k++) begin
            head_ff[k] <= NIL;
         end
      end else begin
         csr_pages_ff <= csr_pages_in;
         pool_ff      <= pool_in;
         total_ff     <= total_in;
         clr_ff       <= clr_in;
         ord_ff       <= ord_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_ORDERS; k++) begin
            head_ff[k] <= head_in[k];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      req_ff        <= req_in;
      page_ff       <= page_in;
      n_ff          <= n_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      h_ff          <= h_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_order_ff  <= rsp_order_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_block_order = rsp_order_ff;
   assign rsp_free_pages  = rsp_free_ff;

   // free page total never exceeds the pool
   a_total_le_pool: assert property (@(posedge clock) disable iff (reset)
      total_ff <= pool_ff) else $error("free page total above pool size");

   // a result beat only appears after a load command
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.res_load)) else $error("result beat without load");

   // working order stays within range
   a_ord_range: assert property (@(posedge clock) disable iff (reset)
      32'(ord_ff) <= NUM_ORDERS) else $error("order register out of range");

endmodule

/* src/bpa_ctrl.sv */
// allocator controller: sequences init, alloc and free over the datapath
module bpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bpa_pkg::dp_stat_type stat,
   output bpa_pkg::dp_cmd_type  cmd
);
   import bpa_pkg::*;

   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_DECODE,
      S_INIT_CLR,
      S_INIT_SETUP,
      S_INIT_STEP,
      S_PUSH_B,
      S_SCAN,
      S_REM_RD,
      S_REM_WR,
      S_SPLIT,
      S_FREE_CHK,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_MERGE_INC,
      S_FINISH
   } state_type;

   state_type    state_ff, state_in;
   res_kind_type res_ff, res_in;

   assign req_ready = state_ff == S_IDLE;

   // sequencing
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      cmd.op       = OP_IDLE;
      cmd.res_load = 1'b0;
      cmd.res_kind = res_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.action == ACT_INIT) begin
               if (stat.n_zero) begin
                  res_in   = RES_BAD;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_INIT_CLR;
               end
            end else if (stat.action == ACT_ALLOC) begin
               if (stat.req_ok) begin
                  cmd.op   = OP_ALLOC_SETUP;
                  state_in = S_SCAN;
               end else begin
                  res_in   = RES_BAD;
                  state_in = S_FINISH;
               end
            end else if (stat.action == ACT_FREE) begin
               cmd.op   = OP_FREE_RD;
               state_in = S_FREE_CHK;
            end else begin
               res_in   = RES_BAD;
               state_in = S_FINISH;
            end
         end
         S_INIT_CLR: begin
            cmd.op = OP_CLR;
            if (stat.clr_last) begin
               state_in = S_INIT_SETUP;
            end
         end
         S_INIT_SETUP: begin
            cmd.op   = OP_INIT_SETUP;
            state_in = S_INIT_STEP;
         end
         S_INIT_STEP: begin
            priority if (stat.pos_done) begin
               res_in   = RES_INIT;
               state_in = S_FINISH;
            end else if (!stat.fits) begin
               cmd.op = OP_INIT_DEC;
            end else begin
               cmd.op   = OP_INIT_PLACE;
               state_in = S_PUSH_B;
            end
         end
         S_PUSH_B: begin
            cmd.op = OP_PUSH_B;
            priority if (stat.action == ACT_INIT) begin
               state_in = S_INIT_STEP;
            end else if (stat.action == ACT_ALLOC) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            priority if (stat.ord_at_max) begin
               res_in   = RES_NOBLK;
               state_in = S_FINISH;
            end else if (stat.head_valid) begin
               cmd.op   = OP_TAKE;
               state_in = S_REM_RD;
            end else begin
               cmd.op = OP_ORD_INC;
            end
         end
         S_REM_RD: begin
            cmd.op   = OP_REM_RD;
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            cmd.op   = OP_REM_WR;
            state_in = (stat.action == ACT_ALLOC) ? S_SPLIT : S_MERGE_INC;
         end
         S_SPLIT: begin
            if (stat.split_more) begin
               cmd.op   = OP_SPLIT;
               state_in = S_PUSH_B;
            end else begin
               cmd.op   = OP_ALLOC_DONE;
               res_in   = RES_BLOCK;
               state_in = S_FINISH;
            end
         end
         S_FREE_CHK: begin
            if (stat.free_ok) begin
               cmd.op   = OP_FREE_OK;
               state_in = S_MERGE_RD;
            end else begin
               res_in   = RES_BAD;
               state_in = S_FINISH;
            end
         end
         S_MERGE_RD: begin
            if (stat.merge_try) begin
               cmd.op   = OP_MERGE_RD;
               state_in = S_MERGE_CHK;
            end else begin
               cmd.op   = OP_FREE_FIN;
               res_in   = RES_BLOCK;
               state_in = S_PUSH_B;
            end
         end
         S_MERGE_CHK: begin
            if (stat.buddy_match) begin
               cmd.op   = OP_MERGE_TAKE;
               state_in = S_REM_RD;
            end else begin
               cmd.op   = OP_FREE_FIN;
               res_in   = RES_BLOCK;
               state_in = S_PUSH_B;
            end
         end
         S_MERGE_INC: begin
            cmd.op   = OP_ORD_INC;
            state_in = S_MERGE_RD;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and result kind
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         res_ff   <= RES_BAD;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   // one request beat at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second beat taken while busy");

endmodule

/* src/buddy_page_allocator_top.sv */
// top level of the binary buddy page allocator
// Binary buddy allocator over PAGES pages with orders 0 to NUM_ORDERS-1. One request
// beat is taken at a time and answered by exactly one response beat; a finished
// response waits in an output register while the next request is taken. After reset
// the block clears its page metadata memory, one entry a cycle, before it takes the
// first request; page count writes are taken at any time. Init clears the metadata
// memory, then carves the pool into blocks, stepping down an order where a block does
// not fit; alloc scans the orders upward and splits the block level by level; free
// merges with the free buddy level by level; each also decodes and responds.
module buddy_page_allocator_top #(
   parameter int PAGES      = bpa_pkg::PAGES_DEF,
   parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
   input logic       clock,
   input logic       reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus,
   bpa_csr_if.sink   csr_bus
);
   import bpa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_bus.ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpa_datapath #(
      .PAGES      (PAGES),
      .NUM_ORDERS (NUM_ORDERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_bus.action),
      .req_request_order (req_bus.request_order),
      .req_page_index    (req_bus.page_index),
      .csr_write         (csr_bus.valid),
      .csr_data          (csr_bus.data),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_block_index   (rsp_bus.block_index),
      .rsp_block_order   (rsp_bus.block_order),
      .rsp_free_pages    (rsp_bus.free_pages)
   );

endmodule
